@@ src/ufsa_pkg.sv @@
// Shared types, constants and helpers for the union-find set aggregator.
// Used by ufsa_table and union_find_set_aggregator_core.
package ufsa_pkg;

  localparam int unsigned ID_COUNT = 16384;
  localparam int unsigned ID_W     = $clog2(ID_COUNT);
  localparam int unsigned CNT_W    = 15;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned ADD_W    = 16;
  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = 96;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t area;
    sum_t home;
    cnt_t size;
    id_t  parent;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_UNION = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_FINAL
  } phase_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_RD,
    ST_F_CHK,
    ST_C_RD,
    ST_C_WR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_U_RDK,
    ST_U_RDG,
    ST_U_WRK,
    ST_U_WRG,
    ST_OUT_RD,
    ST_OUT_CAP
  } state_e;

  function automatic sum_t sat_sum(input sum_t a, input sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic cnt_t sat_cnt(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

@@ src/ufsa_table.sv @@
// Set table: one synchronous memory holding parent, count and totals per id.
// Depends on ufsa_pkg. One write port, one read port with registered data.
module ufsa_table
  import ufsa_pkg::*;
(
  input  logic   clk_i,
  input  id_t    rd_addr_i,
  output entry_t rd_data_o,
  input  logic   wr_en_i,
  input  id_t    wr_addr_i,
  input  entry_t wr_data_i
);

  entry_t mem [ID_COUNT];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

@@ src/union_find_set_aggregator_core.sv @@
// Top level of the union-find set aggregator: command sequencer around the set table.
// Depends on ufsa_pkg and ufsa_table.
//
// Usage:
//   Input beats arrive on s_axis (tdata: cmd, first_id, second_id, home_count,
//   area_value). Every beat returns exactly one output beat on m_axis (tdata:
//   root_id, member_count, home_total, area_total) describing first_id's set.
//   cmd 0 adds homes and area to the set, cmd 1 joins the sets of first_id and
//   second_id (the root with the larger id hangs under the smaller), cmd 2 and 3 query.
//   Find walks the parent chain through the table memory, then rewrites the
//   chain to point at the root. A query takes one find and a read of the root;
//   an add also rewrites the root's totals; a union adds a second find and, if
//   the roots differ, reads and rewrites both roots and runs a final find. One
//   beat is in flight at a time.
//   After reset the table is cleared one entry per cycle, all 16384 entries,
//   during which s_axis_tready_o stays low.
//   The result sits in an output register; a stalled receiver holds it, and
//   the block may take the next beat meanwhile, but holds its final read until
//   the register frees up.
module union_find_set_aggregator_core
  import ufsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cmd[1:0], first_id[15:2], second_id[29:16], home_count[45:30],
  // area_value[61:46], zero pad[63:62]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // root_id[13:0], member_count[28:14], home_total[60:29], area_total[92:61],
  // zero pad[95:93]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  id_t    clr_q, clr_d;
  cmd_e   cmd_q, cmd_d;
  id_t    a_q, a_d, b_q, b_d;
  logic [ADD_W-1:0] home_q, home_d, area_q, area_d;
  id_t    cur_q, cur_d, start_q, start_d, root_q, root_d, ra_q, ra_d;
  id_t    keep_id_q, keep_id_d, gone_id_q, gone_id_d;
  entry_t keep_q, keep_d, gone_q, gone_d;
  logic   out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_q, out_d;

  id_t    rd_addr;
  entry_t rd_data;
  logic   wr_en;
  id_t    wr_addr;
  entry_t wr_data;

  ufsa_table u_table (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_FIRST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    a_q       <= a_d;
    b_q       <= b_d;
    home_q    <= home_d;
    area_q    <= area_d;
    cur_q     <= cur_d;
    start_q   <= start_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    keep_id_q <= keep_id_d;
    gone_id_q <= gone_id_d;
    keep_q    <= keep_d;
    gone_q    <= gone_d;
    out_q     <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    a_d         = a_q;
    b_d         = b_q;
    home_d      = home_q;
    area_d      = area_q;
    cur_d       = cur_q;
    start_d     = start_q;
    root_d      = root_q;
    ra_d        = ra_q;
    keep_id_d   = keep_id_q;
    gone_id_d   = gone_id_q;
    keep_d      = keep_q;
    gone_d      = gone_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    rd_addr     = cur_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = rd_data;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep every entry back to a singleton set
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '{area: '0, home: '0, size: cnt_t'(1), parent: clr_q};
        clr_d   = clr_q + id_t'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = cmd_e'(s_axis_tdata_i[1:0]);
          a_d     = s_axis_tdata_i[15:2];
          b_d     = s_axis_tdata_i[29:16];
          home_d  = s_axis_tdata_i[45:30];
          area_d  = s_axis_tdata_i[61:46];
          cur_d   = s_axis_tdata_i[15:2];
          start_d = s_axis_tdata_i[15:2];
          phase_d = PH_FIRST;
          state_d = ST_F_RD;
        end
      end
      ST_F_RD: begin
        state_d = ST_F_CHK;
      end
      ST_F_CHK: begin
        // a self-pointing entry is the root; otherwise advance up the chain
        if (rd_data.parent == cur_q) begin
          root_d  = cur_q;
          cur_d   = start_q;
          state_d = ST_C_RD;
        end else begin
          cur_d   = rd_data.parent;
          state_d = ST_F_RD;
        end
      end
      ST_C_RD: begin
        if (cur_q != root_q) begin
          state_d = ST_C_WR;
        end else begin
          unique case (phase_q)
            PH_FIRST: begin
              ra_d = root_q;
              priority if (cmd_q == CMD_ADD) begin
                state_d = ST_ADD_RD;
              end else if (cmd_q == CMD_UNION) begin
                cur_d   = b_q;
                start_d = b_q;
                phase_d = PH_SECOND;
                state_d = ST_F_RD;
              end else begin
                state_d = ST_OUT_RD;
              end
            end
            PH_SECOND: begin
              if (root_q == ra_q) begin
                state_d = ST_OUT_RD;
              end else begin
                keep_id_d = (ra_q < root_q) ? ra_q : root_q;
                gone_id_d = (ra_q < root_q) ? root_q : ra_q;
                state_d   = ST_U_RDK;
              end
            end
            PH_FINAL: begin
              state_d = ST_OUT_RD;
            end
            default: begin
              state_d = ST_OUT_RD;
            end
          endcase
        end
      end
      ST_C_WR: begin
        // point this node straight at the root, then follow its old parent
        wr_en          = 1'b1;
        wr_addr        = cur_q;
        wr_data        = rd_data;
        wr_data.parent = root_q;
        cur_d          = rd_data.parent;
        state_d        = ST_C_RD;
      end
      ST_ADD_RD: begin
        rd_addr = root_q;
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        wr_en        = 1'b1;
        wr_addr      = root_q;
        wr_data      = rd_data;
        wr_data.home = sat_sum(rd_data.home, sum_t'(home_q));
        wr_data.area = sat_sum(rd_data.area, sum_t'(area_q));
        state_d      = ST_OUT_RD;
      end
      ST_U_RDK: begin
        rd_addr = keep_id_q;
        state_d = ST_U_RDG;
      end
      ST_U_RDG: begin
        keep_d  = rd_data;
        rd_addr = gone_id_q;
        state_d = ST_U_WRK;
      end
      ST_U_WRK: begin
        // fold the departing root's totals into the surviving root
        wr_en        = 1'b1;
        wr_addr      = keep_id_q;
        wr_data      = keep_q;
        wr_data.size = sat_cnt(keep_q.size, rd_data.size);
        wr_data.home = sat_sum(keep_q.home, rd_data.home);
        wr_data.area = sat_sum(keep_q.area, rd_data.area);
        gone_d       = rd_data;
        state_d      = ST_U_WRG;
      end
      ST_U_WRG: begin
        wr_en   = 1'b1;
        wr_addr = gone_id_q;
        wr_data = '{area: gone_q.area, home: gone_q.home, size: '0, parent: keep_id_q};
        cur_d   = a_q;
        start_d = a_q;
        phase_d = PH_FINAL;
        state_d = ST_F_RD;
      end
      ST_OUT_RD: begin
        rd_addr = root_q;
        state_d = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        rd_addr = root_q;
        // hold here while the previous result is still unclaimed
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = {3'b000, rd_data.area, rd_data.home, rd_data.size, root_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // one beat in flight: an accepted beat drops ready on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a command is in flight");

  // the table is never written while waiting for a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en)
    else $error("table write while idle");

  // a new result only appears out of the capture state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT_CAP))
    else $error("result raised outside capture");

  // no input taken and no result offered during the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("activity during clearing sweep");

endmodule
